FILE: sv/key_repeat_level_control_defines.svh
// Assertion macros shared by the key repeat level control RTL.
`ifndef KEY_REPEAT_LEVEL_CONTROL_DEFINES_SVH
`define KEY_REPEAT_LEVEL_CONTROL_DEFINES_SVH

// Property checked on every rising edge, ignored while reset is low.
`define KRLC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next one.
`define KRLC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/krlc_pkg.sv
// Shared types and constants of the key repeat level control block.
package krlc_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CODE_W  = 16;
    localparam int unsigned VALUE_W = 3;
    localparam int unsigned LEVEL_W = 8;
    localparam int unsigned MS_W    = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam int unsigned IN_TDATA_W  = 56;
    localparam int unsigned IN_TUSER_W  = 3;
    localparam int unsigned OUT_TDATA_W = 24;

    // item kinds carried in tuser
    typedef enum logic [1:0] {
        ACT_FRAME_START = 2'd0,
        ACT_KEY         = 2'd1,
        ACT_FRAME_END   = 2'd2
    } t_action;

    // key values: released, pressed, repeat; anything above is ignored
    localparam logic [VALUE_W-1:0] KEY_VAL_MAX = 3'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SELECT_CODE  = 3'd0,
        CFG_UP_CODE      = 3'd1,
        CFG_DOWN_CODE    = 3'd2,
        CFG_VOLUME_TOP   = 3'd3,
        CFG_BRIGHT_TOP   = 3'd4,
        CFG_REPEAT_DELAY = 3'd5,
        CFG_REPEAT_PER   = 3'd6,
        CFG_SLEEP_GAP    = 3'd7
    } t_cfg_index;

    localparam logic [CODE_W-1:0]  RST_SELECT_CODE  = 16'd296;
    localparam logic [CODE_W-1:0]  RST_UP_CODE      = 16'd12;
    localparam logic [CODE_W-1:0]  RST_DOWN_CODE    = 16'd11;
    localparam logic [LEVEL_W-1:0] RST_VOLUME_TOP   = 8'd20;
    localparam logic [LEVEL_W-1:0] RST_BRIGHT_TOP   = 8'd10;
    localparam logic [MS_W-1:0]    RST_REPEAT_DELAY = 16'd300;
    localparam logic [MS_W-1:0]    RST_REPEAT_PER   = 16'd100;
    localparam logic [MS_W-1:0]    RST_SLEEP_GAP    = 16'd1000;

endpackage

FILE: sv/key_repeat_level_control.sv
// Top level of the key repeat level control block.
//
// Usage
//  - Slave stream carries one item per beat: frame start (with a ms
//    timestamp), key event, or frame end, selected by tuser.
//  - Master stream returns one beat for every input beat: the current
//    volume and brightness levels and two changed flags, which can only be
//    set on a frame end beat.
//  - Config port: i_cfg_we with i_cfg_index / i_cfg_data; write only while
//    the block is idle. The 8-bit registers take the low byte.
//  - Throughput: one item per cycle while the result stream does not stall.
//    An input beat passes the input register, then the result register.
//  - All frame work is short compare/add logic between those registers;
//    the frame-end path (due compare, up step, down step) sets the clock.
//  - Reset: synchronous, active low. Registers go to their defaults, levels
//    and key state to zero, both streams empty.
//  - Stall: a result waiting on m_axis_tready holds the result register;
//    one more item can still sit in the input register, after which
//    s_axis_tready drops until the result is taken.
`include "key_repeat_level_control_defines.svh"

module key_repeat_level_control (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // config write port
    input  logic                                  i_cfg_we,
    input  logic [krlc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [krlc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [31:0] time_ms, [47:32] key_code, [50:48] key_value, [55:51] zero
    input  logic [krlc_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // [1:0] action, [2] is_key
    input  logic [krlc_pkg::IN_TUSER_W-1:0]       s_axis_tuser,
    // result stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [7:0] volume_level, [15:8] brightness_level, [16] volume_changed,
    // [17] brightness_changed, [23:18] zero
    output logic [krlc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

    localparam int unsigned TW = krlc_pkg::TIME_W;
    localparam int unsigned LW = krlc_pkg::LEVEL_W;

    // ---------------- config registers ----------------
    logic [krlc_pkg::CODE_W-1:0]  r_sel_code, r_up_code, r_down_code;
    logic [LW-1:0]                r_vol_top, r_bri_top;
    logic [krlc_pkg::MS_W-1:0]    r_delay, r_period, r_sleep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel_code  <= krlc_pkg::RST_SELECT_CODE;
            r_up_code   <= krlc_pkg::RST_UP_CODE;
            r_down_code <= krlc_pkg::RST_DOWN_CODE;
            r_vol_top   <= krlc_pkg::RST_VOLUME_TOP;
            r_bri_top   <= krlc_pkg::RST_BRIGHT_TOP;
            r_delay     <= krlc_pkg::RST_REPEAT_DELAY;
            r_period    <= krlc_pkg::RST_REPEAT_PER;
            r_sleep     <= krlc_pkg::RST_SLEEP_GAP;
        end else if (i_cfg_we) begin
            case (krlc_pkg::t_cfg_index'(i_cfg_index))
                krlc_pkg::CFG_SELECT_CODE:  r_sel_code  <= i_cfg_data;
                krlc_pkg::CFG_UP_CODE:      r_up_code   <= i_cfg_data;
                krlc_pkg::CFG_DOWN_CODE:    r_down_code <= i_cfg_data;
                krlc_pkg::CFG_VOLUME_TOP:   r_vol_top   <= i_cfg_data[LW-1:0];
                krlc_pkg::CFG_BRIGHT_TOP:   r_bri_top   <= i_cfg_data[LW-1:0];
                krlc_pkg::CFG_REPEAT_DELAY: r_delay     <= i_cfg_data;
                krlc_pkg::CFG_REPEAT_PER:   r_period    <= i_cfg_data;
                krlc_pkg::CFG_SLEEP_GAP:    r_sleep     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    logic r_in_valid, r_out_valid;
    logic w_adv, w_fire, w_in_acc;

    assign w_adv         = !r_out_valid || m_axis_tready;   // result slot free next edge
    assign w_fire        = r_in_valid && w_adv;             // item processed this edge
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // ---------------- input register ----------------
    logic [1:0]                     r_in_action;
    logic                           r_in_is_key;
    logic [TW-1:0]                  r_in_time;
    logic [krlc_pkg::CODE_W-1:0]    r_in_code;
    logic [krlc_pkg::VALUE_W-1:0]   r_in_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_action <= s_axis_tuser[1:0];
            r_in_is_key <= s_axis_tuser[2];
            r_in_time   <= s_axis_tdata[31:0];
            r_in_code   <= s_axis_tdata[47:32];
            r_in_value  <= s_axis_tdata[50:48];
        end
    end

    // ---------------- block state ----------------
    // Held/fresh flags only ever get tested against zero, so one bit each.
    logic [TW-1:0] r_frame_time, r_last_time, r_up_due, r_dn_due;
    logic          r_discard, r_sel_held;
    logic          r_up_held, r_up_fresh, r_dn_held, r_dn_fresh;
    logic [LW-1:0] r_vol, r_bri;

    logic [TW-1:0] n_frame_time, n_last_time, n_up_due, n_dn_due;
    logic          n_discard, n_sel_held;
    logic          n_up_held, n_up_fresh, n_dn_held, n_dn_fresh;
    logic [LW-1:0] n_vol, n_bri;
    logic          n_vol_chg, n_bri_chg;

    // frame-end helpers: key state after the optional sleep clear
    logic          w_k_sel, w_k_up_held, w_k_up_fresh, w_k_dn_held, w_k_dn_fresh;
    logic [TW-1:0] w_k_up_due, w_k_dn_due;
    logic          w_up_go, w_dn_go;
    logic [LW-1:0] w_lvl0, w_lvl1, w_lvl2, w_top;
    logic [TW-1:0] w_gap, w_press_due;
    logic          w_key_ok, w_press;

    assign w_gap       = r_in_time - r_last_time;
    assign w_press     = (r_in_value != '0);
    assign w_press_due = r_frame_time + {{(TW-krlc_pkg::MS_W){1'b0}}, r_delay};
    assign w_key_ok    = !r_discard && r_in_is_key && (r_in_value <= krlc_pkg::KEY_VAL_MAX);

    assign w_k_sel      = r_discard ? 1'b0 : r_sel_held;
    assign w_k_up_held  = r_discard ? 1'b0 : r_up_held;
    assign w_k_up_fresh = r_discard ? 1'b0 : r_up_fresh;
    assign w_k_up_due   = r_discard ? '0   : r_up_due;
    assign w_k_dn_held  = r_discard ? 1'b0 : r_dn_held;
    assign w_k_dn_fresh = r_discard ? 1'b0 : r_dn_fresh;
    assign w_k_dn_due   = r_discard ? '0   : r_dn_due;

    assign w_up_go = w_k_up_fresh || (w_k_up_held && (r_frame_time >= w_k_up_due));
    assign w_dn_go = w_k_dn_fresh || (w_k_dn_held && (r_frame_time >= w_k_dn_due));

    // up step first, then down step on the result; select picks the level
    assign w_lvl0 = w_k_sel ? r_bri : r_vol;
    assign w_top  = w_k_sel ? r_bri_top : r_vol_top;
    assign w_lvl1 = (w_up_go && (w_lvl0 < w_top)) ? w_lvl0 + 1'b1 : w_lvl0;
    assign w_lvl2 = (w_dn_go && (w_lvl1 != '0)) ? w_lvl1 - 1'b1 : w_lvl1;

    always_comb begin
        n_frame_time = r_frame_time;
        n_last_time  = r_last_time;
        n_discard    = r_discard;
        n_sel_held   = r_sel_held;
        n_up_held    = r_up_held;
        n_up_fresh   = r_up_fresh;
        n_up_due     = r_up_due;
        n_dn_held    = r_dn_held;
        n_dn_fresh   = r_dn_fresh;
        n_dn_due     = r_dn_due;
        n_vol        = r_vol;
        n_bri        = r_bri;
        n_vol_chg    = 1'b0;
        n_bri_chg    = 1'b0;
        case (krlc_pkg::t_action'(r_in_action))
            krlc_pkg::ACT_FRAME_START: begin
                n_frame_time = r_in_time;
                n_discard    = w_gap > {{(TW-krlc_pkg::MS_W){1'b0}}, r_sleep};
            end
            krlc_pkg::ACT_KEY: begin
                if (w_key_ok) begin
                    // first match wins: select, then up, then down
                    if (r_in_code == r_sel_code) begin
                        n_sel_held = w_press;
                    end else if (r_in_code == r_up_code) begin
                        n_up_held  = w_press;
                        n_up_fresh = w_press;
                        if (w_press) n_up_due = w_press_due;
                    end else if (r_in_code == r_down_code) begin
                        n_dn_held  = w_press;
                        n_dn_fresh = w_press;
                        if (w_press) n_dn_due = w_press_due;
                    end
                end
            end
            krlc_pkg::ACT_FRAME_END: begin
                n_sel_held = w_k_sel;
                n_up_held  = w_k_up_held;
                n_dn_held  = w_k_dn_held;
                n_up_fresh = w_up_go ? 1'b0 : w_k_up_fresh;
                n_dn_fresh = w_dn_go ? 1'b0 : w_k_dn_fresh;
                n_up_due   = (w_up_go && !w_k_up_fresh)
                           ? w_k_up_due + {{(TW-krlc_pkg::MS_W){1'b0}}, r_period}
                           : w_k_up_due;
                n_dn_due   = (w_dn_go && !w_k_dn_fresh)
                           ? w_k_dn_due + {{(TW-krlc_pkg::MS_W){1'b0}}, r_period}
                           : w_k_dn_due;
                if (w_k_sel) n_bri = w_lvl2;
                else         n_vol = w_lvl2;
                n_vol_chg   = (n_vol != r_vol);
                n_bri_chg   = (n_bri != r_bri);
                n_last_time = r_frame_time;
                n_discard   = 1'b0;
            end
            default: ;  // spare action code: no change
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_time <= '0;
            r_last_time  <= '0;
            r_discard    <= 1'b0;
            r_sel_held   <= 1'b0;
            r_up_held    <= 1'b0;
            r_up_fresh   <= 1'b0;
            r_up_due     <= '0;
            r_dn_held    <= 1'b0;
            r_dn_fresh   <= 1'b0;
            r_dn_due     <= '0;
            r_vol        <= '0;
            r_bri        <= '0;
        end else if (w_fire) begin
            r_frame_time <= n_frame_time;
            r_last_time  <= n_last_time;
            r_discard    <= n_discard;
            r_sel_held   <= n_sel_held;
            r_up_held    <= n_up_held;
            r_up_fresh   <= n_up_fresh;
            r_up_due     <= n_up_due;
            r_dn_held    <= n_dn_held;
            r_dn_fresh   <= n_dn_fresh;
            r_dn_due     <= n_dn_due;
            r_vol        <= n_vol;
            r_bri        <= n_bri;
        end
    end

    // ---------------- result register ----------------
    logic [LW-1:0] r_out_vol, r_out_bri;
    logic          r_out_vol_chg, r_out_bri_chg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_vol     <= n_vol;
            r_out_bri     <= n_bri;
            r_out_vol_chg <= n_vol_chg;
            r_out_bri_chg <= n_bri_chg;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_bri_chg, r_out_vol_chg, r_out_bri, r_out_vol};

    // ---------------- assertions ----------------
    `KRLC_ASSERT_NEXT(a_flags_only_on_end,
        w_fire && (r_in_action != krlc_pkg::ACT_FRAME_END),
        !r_out_vol_chg && !r_out_bri_chg,
        "changed flag set on an item that is not a frame end")

    `KRLC_ASSERT_NEXT(a_end_clears_discard,
        w_fire && (r_in_action == krlc_pkg::ACT_FRAME_END),
        !r_discard,
        "discard mark survived a frame end")

    `KRLC_ASSERT_NEXT(a_vol_flag_matches,
        w_fire,
        r_out_vol_chg == (r_vol != $past(r_vol)),
        "volume changed flag disagrees with the stored level")

    `KRLC_ASSERT_NEXT(a_input_held_in_stall,
        r_in_valid && !w_adv,
        r_in_valid && $stable(r_in_time) && $stable(r_in_action),
        "queued item lost or overwritten while the result stalls")

endmodule

FILE: dv/key_repeat_level_control_tb.sv
// Self-checking stream testbench for the key repeat level control block.
`timescale 1ns / 1ps

module key_repeat_level_control_tb;

    // item kinds and reset key codes, short forms for the tables below
    localparam logic [1:0]  A_START  = krlc_pkg::ACT_FRAME_START;
    localparam logic [1:0]  A_KEY    = krlc_pkg::ACT_KEY;
    localparam logic [1:0]  A_END    = krlc_pkg::ACT_FRAME_END;
    localparam logic [15:0] K_SELECT = krlc_pkg::RST_SELECT_CODE;
    localparam logic [15:0] K_UP     = krlc_pkg::RST_UP_CODE;
    localparam logic [15:0] K_DOWN   = krlc_pkg::RST_DOWN_CODE;

    // action code 3 is not an item kind of the block; it must pass through untouched
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 1950;
    localparam int NUM_PHASES   = 7;
    localparam int STUCK_LIMIT  = 2000;  // cycles with no beat on either side
    localparam int HOLD_CYCLES  = 60;    // long receiver hold-off

    typedef struct {
        logic [1:0]  action;
        logic [31:0] stamp;
        logic        is_key;
        logic [15:0] code;
        logic [2:0]  value;
    } t_key_item;

    typedef struct {
        logic [7:0] volume;
        logic [7:0] brightness;
        logic       vol_moved;
        logic       bri_moved;
    } t_level_report;

    // directed row; typed = 1 means the levels below are checked as written
    typedef struct {
        logic [1:0]  action;
        logic [31:0] stamp;
        logic        is_key;
        logic [15:0] code;
        logic [2:0]  value;
        bit          typed;
        logic [7:0]  volume;
        logic [7:0]  brightness;
        logic        vol_moved;
        logic        bri_moved;
    } t_stim_row;

    typedef struct {
        logic [15:0] select_code;
        logic [15:0] up_code;
        logic [15:0] down_code;
        logic [7:0]  vol_top;
        logic [7:0]  bri_top;
        logic [15:0] delay_ms;
        logic [15:0] period_ms;
        logic [15:0] gap_ms;
    } t_reg_set;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [krlc_pkg::CFG_IDX_W-1:0]   i_cfg_index;
    logic [krlc_pkg::CFG_DATA_W-1:0]  i_cfg_data;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [krlc_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic [krlc_pkg::IN_TUSER_W-1:0]  s_axis_tuser;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [krlc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    key_repeat_level_control dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [31:0] stamp, [47:32] code, [50:48] value
        .s_axis_tuser  (s_axis_tuser),   // [1:0] action, [2] is_key
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // [7:0] vol, [15:8] bri, [16] vol chg, [17] bri chg
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Level predictor: own copy of registers and key state
    // ------------------------------------------------------------------
    logic [15:0] cfg_select  = krlc_pkg::RST_SELECT_CODE;
    logic [15:0] cfg_up      = krlc_pkg::RST_UP_CODE;
    logic [15:0] cfg_down    = krlc_pkg::RST_DOWN_CODE;
    logic [7:0]  cfg_vol_top = krlc_pkg::RST_VOLUME_TOP;
    logic [7:0]  cfg_bri_top = krlc_pkg::RST_BRIGHT_TOP;
    logic [15:0] cfg_delay   = krlc_pkg::RST_REPEAT_DELAY;
    logic [15:0] cfg_period  = krlc_pkg::RST_REPEAT_PER;
    logic [15:0] cfg_gap     = krlc_pkg::RST_SLEEP_GAP;

    logic [31:0] frame_at      = '0;
    logic [31:0] prev_frame_at = '0;
    logic        drop_frame    = 1'b0;
    logic [1:0]  select_hold   = '0;
    logic [1:0]  up_hold       = '0;
    logic [1:0]  up_new        = '0;
    logic [31:0] up_due        = '0;
    logic [1:0]  down_hold     = '0;
    logic [1:0]  down_new      = '0;
    logic [31:0] down_due      = '0;
    logic [7:0]  vol_now       = '0;
    logic [7:0]  bri_now       = '0;

    // One direction at frame end: a fresh press steps at once, a held key
    // steps once its due time is reached and then re-arms a period later.
    function automatic void step_key(input bit raise, inout logic [1:0] hold,
                                     inout logic [1:0] fresh, inout logic [31:0] due);
        logic [7:0] lvl;
        logic [7:0] top;
        if (fresh != 0 || (hold != 0 && frame_at >= due)) begin
            lvl = (select_hold != 0) ? bri_now : vol_now;
            top = (select_hold != 0) ? cfg_bri_top : cfg_vol_top;
            // above the top after a lowered maximum: up leaves it, down still lowers
            if (raise && lvl < top)
                lvl = lvl + 8'd1;
            else if (!raise && lvl > 0)
                lvl = lvl - 8'd1;
            if (select_hold != 0)
                bri_now = lvl;
            else
                vol_now = lvl;
            if (fresh != 0)
                fresh = '0;
            else
                due = due + {16'd0, cfg_period};
        end
    endfunction

    function automatic t_level_report advance_levels(input t_key_item it);
        t_level_report rep;
        logic [7:0]    vol_was;
        logic [7:0]    bri_was;
        bit            at_end;
        vol_was = vol_now;
        bri_was = bri_now;
        at_end  = 1'b0;
        case (it.action)
            A_START: begin
                frame_at   = it.stamp;
                // gap taken mod 2^32 so a wrapped stamp still measures short
                drop_frame = (it.stamp - prev_frame_at) > {16'd0, cfg_gap};
            end
            A_KEY: begin
                if (!drop_frame && it.is_key && it.value <= krlc_pkg::KEY_VAL_MAX) begin
                    // select beats up beats down when codes are shared
                    if (it.code == cfg_select) begin
                        select_hold = it.value[1:0];
                    end else if (it.code == cfg_up) begin
                        up_hold = it.value[1:0];
                        up_new  = it.value[1:0];
                        if (it.value != 0)
                            up_due = frame_at + {16'd0, cfg_delay};
                    end else if (it.code == cfg_down) begin
                        down_hold = it.value[1:0];
                        down_new  = it.value[1:0];
                        if (it.value != 0)
                            down_due = frame_at + {16'd0, cfg_delay};
                    end
                end
            end
            A_END: begin
                at_end = 1'b1;
                if (drop_frame) begin
                    select_hold = '0;
                    up_hold     = '0;
                    up_new      = '0;
                    up_due      = '0;
                    down_hold   = '0;
                    down_new    = '0;
                    down_due    = '0;
                end
                step_key(1'b1, up_hold, up_new, up_due);
                step_key(1'b0, down_hold, down_new, down_due);
                prev_frame_at = frame_at;
                drop_frame    = 1'b0;
            end
            default: ;
        endcase
        rep.volume     = vol_now;
        rep.brightness = bri_now;
        rep.vol_moved  = at_end && (vol_now != vol_was);
        rep.bri_moved  = at_end && (bri_now != bri_was);
        return rep;
    endfunction

    // ------------------------------------------------------------------
    // Expected levels, result check, mismatch reporting
    // ------------------------------------------------------------------
    t_level_report pending_levels[$];
    int            mismatch_count = 0;
    int            result_beats   = 0;

    task automatic flag_mismatch(input string field, input logic [23:0] got,
                                 input logic [23:0] want);
        $display("MISMATCH beat %0d %s: got 0x%0h, want 0x%0h",
                 result_beats, field, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_level_report want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_levels.size() == 0) begin
                flag_mismatch("result with nothing pending", m_axis_tdata, 24'd0);
            end else begin
                want = pending_levels.pop_front();
                if (m_axis_tdata[7:0] !== want.volume)
                    flag_mismatch("volume_level", 24'(m_axis_tdata[7:0]),
                                  24'(want.volume));
                if (m_axis_tdata[15:8] !== want.brightness)
                    flag_mismatch("brightness_level", 24'(m_axis_tdata[15:8]),
                                  24'(want.brightness));
                if (m_axis_tdata[16] !== want.vol_moved)
                    flag_mismatch("volume_changed", 24'(m_axis_tdata[16]),
                                  24'(want.vol_moved));
                if (m_axis_tdata[17] !== want.bri_moved)
                    flag_mismatch("brightness_changed", 24'(m_axis_tdata[17]),
                                  24'(want.bri_moved));
            end
            result_beats++;
        end
    end

    // ------------------------------------------------------------------
    // Result sink: random back-pressure, calm stretches, long hold-offs.
    // A hold-off is asked for by bumping stall_requests; the count of
    // cycles runs here so the sender keeps offering in the meantime.
    // ------------------------------------------------------------------
    bit calm           = 1'b0;
    int stall_requests = 0;

    initial begin : result_sink
        int hold_left;
        int served;
        hold_left = 0;
        served    = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (served != stall_requests) begin
                served    = stall_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm || ($urandom_range(0, 99) >= 14);
            end
        end
    end

    // Watchdog: nothing moving on either stream for too long ends the run
    int stuck_cycles = 0;

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    int live_items = 0;

    // Offer one beat with random idle cycles ahead of it; the predictor
    // runs at the edge the beat is taken.
    task automatic offer_item(input t_key_item it, input bit typed,
                              input t_level_report typed_want);
        t_level_report rep;
        while (!calm && $urandom_range(0, 99) < 14) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, it.value, it.code, it.stamp};
        s_axis_tuser  <= {it.is_key, it.action};
        do @(posedge i_clk); while (!s_axis_tready);
        rep = advance_levels(it);
        if (typed)
            pending_levels.push_back(typed_want);
        else
            pending_levels.push_back(rep);
    endtask

    // Stop sending and wait for every pending result, plus some settling
    task automatic wait_drained(input int settle);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_levels.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    // Writes all eight registers in index order, one per cycle; the 8-bit
    // registers get junk in the upper byte, which the block must drop.
    task automatic apply_setting(input t_reg_set rs);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= krlc_pkg::CFG_SELECT_CODE;
        i_cfg_data  <= rs.select_code;
        @(posedge i_clk);
        i_cfg_index <= krlc_pkg::CFG_UP_CODE;
        i_cfg_data  <= rs.up_code;
        @(posedge i_clk);
        i_cfg_index <= krlc_pkg::CFG_DOWN_CODE;
        i_cfg_data  <= rs.down_code;
        @(posedge i_clk);
        i_cfg_index <= krlc_pkg::CFG_VOLUME_TOP;
        i_cfg_data  <= {8'($urandom), rs.vol_top};
        @(posedge i_clk);
        i_cfg_index <= krlc_pkg::CFG_BRIGHT_TOP;
        i_cfg_data  <= {8'($urandom), rs.bri_top};
        @(posedge i_clk);
        i_cfg_index <= krlc_pkg::CFG_REPEAT_DELAY;
        i_cfg_data  <= rs.delay_ms;
        @(posedge i_clk);
        i_cfg_index <= krlc_pkg::CFG_REPEAT_PER;
        i_cfg_data  <= rs.period_ms;
        @(posedge i_clk);
        i_cfg_index <= krlc_pkg::CFG_SLEEP_GAP;
        i_cfg_data  <= rs.gap_ms;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_select  = rs.select_code;
        cfg_up      = rs.up_code;
        cfg_down    = rs.down_code;
        cfg_vol_top = rs.vol_top;
        cfg_bri_top = rs.bri_top;
        cfg_delay   = rs.delay_ms;
        cfg_period  = rs.period_ms;
        cfg_gap     = rs.gap_ms;
    endtask

    // One well-formed frame: start stamp spaced from the last frame, a few
    // key beats mostly on the configured codes, then the frame end.
    // Now and then the start is left out.
    task automatic send_frame(input t_level_report no_want);
        t_key_item   it;
        logic [31:0] delta;
        int          span;
        int          pick;
        int          n_keys;
        span = (cfg_period < 200) ? int'(cfg_period) + 50 : 250;
        if (span > int'(cfg_gap))
            span = int'(cfg_gap);
        case ($urandom_range(0, 9))
            0:       delta = {16'd0, cfg_gap} + 32'd1 + 32'($urandom_range(0, 3));
            1:       delta = $urandom;  // far jump, wraps the stamp
            2:       delta = {16'd0, cfg_gap};
            default: delta = 32'($urandom_range(0, span));
        endcase
        if ($urandom_range(0, 15) != 0) begin
            it = '{A_START, prev_frame_at + delta, 1'($urandom_range(0, 1)),
                   16'($urandom), 3'($urandom)};
            offer_item(it, 1'b0, no_want);
            live_items++;
        end
        n_keys = $urandom_range(0, 4);
        repeat (n_keys) begin
            it.action = A_KEY;
            it.stamp  = $urandom;
            it.is_key = ($urandom_range(0, 19) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 30)
                it.code = cfg_up;
            else if (pick < 60)
                it.code = cfg_down;
            else if (pick < 80)
                it.code = cfg_select;
            else if (pick < 90)
                it.code = 16'($urandom);
            else if (pick < 95)
                it.code = 16'h0000;
            else
                it.code = 16'hFFFF;
            it.value = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 2))
                                                    : 3'($urandom_range(3, 7));
            offer_item(it, 1'b0, no_want);
            live_items++;
        end
        it = '{A_END, $urandom, 1'($urandom_range(0, 1)), 16'($urandom), 3'($urandom)};
        offer_item(it, 1'b0, no_want);
        live_items++;
    endtask

    // Directed opening under reset settings. Only the first rows carry typed
    // levels; the rest go through the predictor.
    t_stim_row directed_rows [26] = '{
        // reset levels, then a fresh up press steps volume on frame end
        '{A_START, 32'd0, 1'b0, 16'd0, 3'd0, 1'b1, 8'd0, 8'd0, 1'b0, 1'b0},
        '{A_KEY, 32'd0, 1'b1, K_UP, 3'd1, 1'b1, 8'd0, 8'd0, 1'b0, 1'b0},
        '{A_END, 32'd0, 1'b0, 16'd0, 3'd0, 1'b1, 8'd1, 8'd0, 1'b1, 1'b0},
        // held, not yet due; then due exactly at the delay
        '{A_START, 32'd200, 1'b0, 16'd0, 3'd0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0},
        '{A_END, 32'd0, 1'b0, 16'd0, 3'd0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0},
        '{A_START, 32'd300, 1'b0, 16'd0, 3'd0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0},
        '{A_END, 32'd0, 1'b0, 16'd0, 3'd0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0},
        // select held: a repeat-valued up steps brightness
        '{A_KEY, 32'd0, 1'b1, K_SELECT, 3'd1, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0},
        '{A_KEY, 32'd0, 1'b1, K_UP, 3'd2, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0},
        '{A_END, 32'd0, 1'b0, 16'd0, 3'd0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0},
        // not a key event, value above repeat, unused action: all ignored
        '{A_KEY, 32'd0, 1'b0, K_UP, 3'd1, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0},
        '{A_KEY, 32'd0, 1'b1, K_UP, 3'd7, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0},
        '{ACT_UNUSED, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 3'd7, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0},
        // releases, then a down press
        '{A_KEY, 32'd0, 1'b1, K_SELECT, 3'd0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0},
        '{A_KEY, 32'd0, 1'b1, K_UP, 3'd0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0},
        '{A_KEY, 32'd0, 1'b1, K_DOWN, 3'd1, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0},
        '{A_END, 32'd0, 1'b0, 16'd0, 3'd0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0},
        // long sleep: the frame's keys are dropped and held keys cleared
        '{A_START, 32'hFFFF_FFFF, 1'b0, 16'd0, 3'd0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0},
        '{A_KEY, 32'd0, 1'b1, K_UP, 3'd1, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0},
        '{A_END, 32'd0, 1'b0, 16'd0, 3'd0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0},
        // stamp wraps past zero: short gap, frame kept
        '{A_START, 32'd5, 1'b0, 16'd0, 3'd0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0},
        '{A_KEY, 32'd0, 1'b1, 16'hFFFF, 3'd2, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0},
        '{A_KEY, 32'd0, 1'b1, K_DOWN, 3'd1, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0},
        '{A_END, 32'd0, 1'b0, 16'd0, 3'd0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0},
        // frame ends with no frame start between them
        '{A_END, 32'd0, 1'b0, 16'd0, 3'd0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0},
        '{A_END, 32'd0, 1'b1, 16'd0, 3'd0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0}
    };

    // Register settings for the random phases after the first
    t_reg_set reg_sets [NUM_PHASES-1] = '{
        // widest tops, no delay, shortest period, longest sleep gap
        '{16'd296, 16'd12, 16'd11, 8'd255, 8'd255, 16'd0, 16'd1, 16'hFFFF},
        // extreme codes, tops pulled below the levels, zero sleep gap
        '{16'd0, 16'hFFFF, 16'd1, 8'd3, 8'd2, 16'hFFFF, 16'hFFFF, 16'd0},
        // one code for all three keys: select wins, tops at zero
        '{16'd5, 16'd5, 16'd5, 8'd0, 8'd0, 16'd50, 16'd20, 16'd500},
        // select shares the up code
        '{16'd7, 16'd7, 16'd9, 8'd40, 8'd40, 16'd100, 16'd30, 16'd2000},
        // up shares the down code: up wins
        '{16'd100, 16'd200, 16'd200, 8'd100, 8'd100, 16'd10, 16'd5, 16'd300},
        // back to reset values
        '{16'd296, 16'd12, 16'd11, 8'd20, 8'd10, 16'd300, 16'd100, 16'd1000}
    };

    initial begin : stimulus
        t_stim_row     row;
        t_key_item     it;
        t_level_report no_want;
        t_level_report typed_want;
        int            phase_start;
        int            phase_end;
        int            mid;
        bit            squeezed;
        bit            paused;
        no_want       = '{default: '0};
        squeezed      = 1'b0;
        paused        = 1'b0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= krlc_pkg::CFG_SELECT_CODE;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            row        = directed_rows[i];
            it         = '{row.action, row.stamp, row.is_key, row.code, row.value};
            typed_want = '{row.volume, row.brightness, row.vol_moved, row.bri_moved};
            offer_item(it, row.typed, typed_want);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) begin
                wait_drained(4);
                apply_setting(reg_sets[ph-1]);
            end
            // first half of the second phase runs with no idling either side
            if (ph == 1)
                calm <= 1'b1;
            phase_start = live_items;
            phase_end   = (ph + 1) * RANDOM_ITEMS / NUM_PHASES;
            mid         = (phase_start + phase_end) / 2;
            while (live_items < phase_end) begin
                if (ph == 1 && calm && live_items >= mid)
                    calm <= 1'b0;
                // receiver holds off while beats keep coming: input side fills
                if (ph == 2 && !squeezed && live_items >= mid) begin
                    squeezed = 1'b1;
                    stall_requests <= stall_requests + 1;
                end
                // sender waits for every pending result before carrying on
                if (ph == 3 && !paused && live_items >= mid) begin
                    paused = 1'b1;
                    wait_drained(0);
                end
                if ($urandom_range(0, 99) < 85) begin
                    send_frame(no_want);
                end else begin
                    // noise beat: any action, any field content
                    it = '{2'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)),
                           16'($urandom), 3'($urandom)};
                    offer_item(it, 1'b0, no_want);
                    live_items++;
                end
            end
        end

        wait_drained(8);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
